FILE: rtl/rgb_to_hsv_top_defines.svh
// rgb_to_hsv_top_defines.svh: assertion macros for the rgb_to_hsv checker.
// No dependencies.
`ifndef RGB_TO_HSV_TOP_DEFINES_SVH
`define RGB_TO_HSV_TOP_DEFINES_SVH

// implication checked at every clock, disabled in reset
`define RTH_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgb_to_hsv check failed");

// next-cycle implication
`define RTH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgb_to_hsv check failed");

`endif

FILE: rtl/rth_pkg.sv
// rth_pkg: shared constants for rgb_to_hsv.
// No dependencies.
package rth_pkg;
    localparam int CHANNEL_BITS_DEF = 8;
    // hue sector offsets in sixths
    localparam logic [2:0] SECT_RED   = 3'd0;
    localparam logic [2:0] SECT_GREEN = 3'd2;
    localparam logic [2:0] SECT_BLUE  = 3'd4;
endpackage

FILE: rtl/rth_stream_if.sv
// rth_stream_if: valid/ready channel carrying three channel fields.
// No dependencies.
interface rth_stream_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] f0;
    logic [W-1:0] f1;
    logic [W-1:0] f2;
    modport source (output valid, f0, f1, f2, input ready);
    modport sink   (input valid, f0, f1, f2, output ready);
endinterface

FILE: rtl/rth_divider.sv
// rth_divider: pipelined restoring divider, one quotient bit per stage.
// Depends on nothing; sideband travels alongside the quotient.
module rth_divider #(
    parameter int NW = 16,   // numerator width
    parameter int DW = 12,   // divisor width
    parameter int QW = 8,    // quotient bits (quotient known to fit)
    parameter int SW = 8     // sideband width
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output logic [SW-1:0] o_side
);
    localparam int RW = DW + 1;
    // index s holds the state after s quotient bits; remainder below den
    logic [QW:1]         r_v;
    logic [RW-1:0]       r_rem  [1:QW];
    logic [NW-1:0]       r_num  [1:QW];
    logic [DW-1:0]       r_den  [1:QW];
    logic [QW-1:0]       r_quo  [1:QW];
    logic [SW-1:0]       r_side [1:QW];

    // Top NW-QW numerator bits are below den by construction (quotient fits),
    // so they preload the remainder; each stage then brings in one more bit.
    for (genvar s = 0; s < QW; s++) begin : g_st
        logic          c_v;
        logic [NW-1:0] c_num;
        logic [DW-1:0] c_den;
        logic [QW-1:0] c_quo;
        logic [SW-1:0] c_side;
        logic [RW:0]   n_sh;
        logic [RW:0]   n_trial;
        logic [RW-1:0] n_rem;
        if (s == 0) begin : g_first
            assign c_v    = i_valid;
            assign c_num  = i_num;
            assign c_den  = i_den;
            assign c_quo  = '0;
            assign c_side = i_side;
            assign n_sh   = ((RW+1)'(i_num >> QW) << 1) | (RW+1)'(i_num[QW-1]);
        end else begin : g_next
            assign c_v    = r_v[s];
            assign c_num  = r_num[s];
            assign c_den  = r_den[s];
            assign c_quo  = r_quo[s];
            assign c_side = r_side[s];
            assign n_sh   = {r_rem[s], r_num[s][QW-1-s]};
        end
        always_comb begin
            n_trial = n_sh - (RW+1)'(c_den);
            n_rem   = n_trial[RW] ? n_sh[RW-1:0] : n_trial[RW-1:0];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (i_en) begin
                r_v[s+1] <= c_v;
            end
            if (i_en) begin
                r_rem[s+1]  <= n_rem;
                r_num[s+1]  <= c_num;
                r_den[s+1]  <= c_den;
                r_quo[s+1]  <= {c_quo[QW-2:0], ~n_trial[RW]};
                r_side[s+1] <= c_side;
            end
        end
    end

    assign o_valid = r_v[QW];
    assign o_quo   = r_quo[QW];
    assign o_side  = r_side[QW];
endmodule

FILE: rtl/rth_front.sv
// rth_front: max/min/sector stage and numerator products.
// Depends on rth_pkg.
module rth_front #(
    parameter int CW = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [CW-1:0]   i_red,
    input  logic [CW-1:0]   i_green,
    input  logic [CW-1:0]   i_blue,
    output logic            o_valid,
    output logic [2*CW+2:0] o_hnum,
    output logic [CW+2:0]   o_hden,
    output logic [2*CW-1:0] o_snum,
    output logic [CW-1:0]   o_sden,
    output logic [CW-1:0]   o_val,
    output logic            o_grey
);
    import rth_pkg::*;
    localparam logic [CW-1:0] FS = '1;

    // stage 1 registers
    logic          r_v1;
    logic [CW-1:0] r_mx, r_d, r_hi, r_lo;
    logic [2:0]    r_off;
    logic [CW-1:0] n_mx, n_mn, n_hi, n_lo;
    logic [2:0]    n_off;

    always_comb begin
        n_mx = i_red;
        n_mn = i_red;
        if (i_green > n_mx) n_mx = i_green;
        if (i_blue  > n_mx) n_mx = i_blue;
        if (i_green < n_mn) n_mn = i_green;
        if (i_blue  < n_mn) n_mn = i_blue;
        if (i_red == n_mx) begin
            n_off = SECT_RED;   n_hi = i_green; n_lo = i_blue;
        end else if (i_green == n_mx) begin
            n_off = SECT_GREEN; n_hi = i_blue;  n_lo = i_red;
        end else begin
            n_off = SECT_BLUE;  n_hi = i_red;   n_lo = i_green;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (i_en) r_v1 <= i_valid;
        if (i_en) begin
            r_mx  <= n_mx;
            r_d   <= n_mx - n_mn;
            r_hi  <= n_hi;
            r_lo  <= n_lo;
            r_off <= n_off;
        end
    end

    // stage 2: position t, then multiply by full scale (FS*x = (x<<CW)-x)
    logic [CW+2:0] n_t, n_od, n_6d;
    always_comb begin
        n_od = (CW+3)'(r_off) * (CW+3)'(r_d);
        n_6d = (CW+3)'(r_d) * (CW+3)'(6);
        if (n_od + (CW+3)'(r_hi) >= (CW+3)'(r_lo))
            n_t = n_od + (CW+3)'(r_hi) - (CW+3)'(r_lo);
        else
            n_t = n_od + n_6d + (CW+3)'(r_hi) - (CW+3)'(r_lo);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else if (i_en) o_valid <= r_v1;
        if (i_en) begin
            o_hnum <= ((2*CW+3)'(n_t) << CW) - (2*CW+3)'(n_t);
            o_hden <= n_6d;
            o_snum <= ((2*CW)'(r_d) << CW) - (2*CW)'(r_d);
            o_sden <= r_mx;
            o_val  <= CW'(((2*CW)'(r_mx) * (2*CW)'(FS)) >> CW);
            o_grey <= (r_d == '0);
        end
    end
endmodule

FILE: rtl/rgb_to_hsv_top.sv
// rgb_to_hsv_top: pipelined 8-bit RGB to HSV conversion.
// Depends on rth_pkg, rth_stream_if, rth_front, rth_divider.
//
//   channel   dir  fields (f0, f1, f2)
//   s_pix     in   red, green, blue
//   m_hsv     out  hue, saturation, brightness
//
// One pixel per clock sustained while the output is taken; the pipe is two front
// stages, one divider stage per quotient bit, and the output register.
// Two restoring dividers (hue, saturation) run side by side in lockstep.
// The whole pipe advances when the output register is free or being taken;
// a stall freezes every stage, so nothing is lost or repeated.
// Reset (synchronous, active low) clears only the valid bits.
// Black pixels use a divisor of 1 for saturation and mask the result to 0;
// grey pixels mask hue to 0.
module rgb_to_hsv_top #(
    parameter int CHANNEL_BITS = rth_pkg::CHANNEL_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rth_stream_if.sink   s_pix,
    rth_stream_if.source m_hsv
);
    import rth_pkg::*;
    localparam int CW = CHANNEL_BITS;

    logic en;
    logic f_v;
    logic [2*CW+2:0] f_hnum;
    logic [CW+2:0]   f_hden;
    logic [2*CW-1:0] f_snum;
    logic [CW-1:0]   f_sden;
    logic [CW-1:0]   f_val;
    logic            f_grey;

    // pipe moves when output register empty or transferring
    assign en          = !m_hsv.valid || m_hsv.ready;
    assign s_pix.ready = en;

    rth_front #(.CW(CW)) u_front (
        .i_clk, .i_rst_n, .i_en(en),
        .i_valid(s_pix.valid && en),
        .i_red(s_pix.f0), .i_green(s_pix.f1), .i_blue(s_pix.f2),
        .o_valid(f_v), .o_hnum(f_hnum), .o_hden(f_hden),
        .o_snum(f_snum), .o_sden(f_sden), .o_val(f_val), .o_grey(f_grey)
    );

    logic          h_v, s_v;
    logic [CW-1:0] h_q, s_q, h_side, s_side;
    logic [CW:0]   h_sd;
    logic          s_black;

    // hue divisor: 6d, forced to 1 when grey (quotient masked later)
    rth_divider #(.NW(2*CW+3), .DW(CW+3), .QW(CW), .SW(CW+1)) u_hdiv (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(f_v),
        .i_num(f_grey ? '0 : f_hnum),
        .i_den(f_grey ? (CW+3)'(1) : f_hden),
        .i_side({f_grey, f_val}),
        .o_valid(h_v), .o_quo(h_q), .o_side(h_sd)
    );

    rth_divider #(.NW(2*CW), .DW(CW), .QW(CW), .SW(CW+1)) u_sdiv (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(f_v),
        .i_num((f_sden == '0) ? '0 : f_snum),
        .i_den((f_sden == '0) ? CW'(1) : f_sden),
        .i_side({(f_sden == '0), f_val}),
        .o_valid(s_v), .o_quo(s_q), .o_side({s_black, s_side})
    );

    assign h_side = h_sd[CW-1:0];

    logic          r_ov;
    logic [CW-1:0] r_hue, r_sat, r_bri;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (en) r_ov <= h_v && s_v;
        if (en) begin
            r_hue <= h_sd[CW] ? '0 : h_q;
            r_sat <= s_black ? '0 : s_q;
            r_bri <= (h_side == s_side) ? h_side : s_side;
        end
    end

    assign m_hsv.valid = r_ov;
    assign m_hsv.f0    = r_hue;
    assign m_hsv.f1    = r_sat;
    assign m_hsv.f2    = r_bri;
endmodule

FILE: rtl/rth_checker.sv
// rth_checker: port-level checks for rgb_to_hsv_top, bound to the top.
// Depends on rth_stream_if and rgb_to_hsv_top_defines.svh.
`include "rgb_to_hsv_top_defines.svh"
module rth_checker #(
    parameter int CW = 8
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input logic [CW-1:0] hue,
    input logic [CW-1:0] sat,
    input logic [CW-1:0] bri
);
    `RTH_ASSERT_NEXT(a_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid && $stable(hue) && $stable(sat) && $stable(bri))
    `RTH_ASSERT_IMPL(a_ready, i_clk, i_rst_n, !out_valid, in_ready)
    `RTH_ASSERT_IMPL(a_bri, i_clk, i_rst_n, out_valid, bri != {CW{1'b1}})
    `RTH_ASSERT_IMPL(a_hue, i_clk, i_rst_n, out_valid, hue != {CW{1'b1}})
endmodule

bind rgb_to_hsv_top rth_checker #(.CW(CHANNEL_BITS)) u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_ready(s_pix.ready),
    .out_valid(m_hsv.valid), .out_ready(m_hsv.ready),
    .hue(m_hsv.f0), .sat(m_hsv.f1), .bri(m_hsv.f2)
);
